@@ hdl/assert_macros.svh @@
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EHP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ehp_pkg.sv @@
package ehp_pkg;

  // Header layout (byte positions from frame start)
  localparam int ETH_LEN       = 14;
  localparam int IP_MIN_LEN    = 20;
  localparam int TCP_MIN_LEN   = 20;
  localparam int UDP_LEN       = 8;
  localparam int POS_VER_IHL   = ETH_LEN;
  localparam int POS_PROTO     = ETH_LEN + 9;
  localparam int POS_SRC_ADDR  = ETH_LEN + 12;
  localparam int POS_DST_ADDR  = ETH_LEN + 16;
  localparam int MIN_L4_OFFSET = ETH_LEN + IP_MIN_LEN;

  localparam logic [3:0] IP_VERSION    = 4'd4;
  localparam logic [3:0] IHL_MIN       = 4'd5;
  localparam logic [7:0] TCP_PROTO_NUM = 8'd6;
  localparam logic [7:0] UDP_PROTO_NUM = 8'd17;
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_HDR   = 3'd2;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_TRUNCATED = 3'd1,
    STATUS_BAD_HDR   = 3'd2,
    STATUS_BAD_PROTO = 3'd3,
    STATUS_OVERSIZE  = 3'd4
  } status_t;

  // Per-frame header state captured byte by byte
  typedef struct packed {
    logic [3:0]  header_len_words;
    logic [7:0]  proto_number;
    logic [31:0] source_addr_reg;
    logic [31:0] dest_addr_reg;
    logic [31:0] port_pair_reg;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [7:0]  flag_reg;
    logic [3:0]  data_offset_words;
    logic [2:0]  error_code;
  } hdr_state_t;

endpackage

@@ hdl/ehp_in_if.sv @@
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

@@ hdl/ehp_out_if.sv @@
interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        is_tcp;
  logic [31:0] src_address;
  logic [31:0] dst_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [7:0]  tcp_flag_bits;
  logic [7:0]  payload_offset;
  logic [14:0] payload_length;

  modport source (
    output valid, output status, output is_tcp, output src_address, output dst_address,
    output source_port, output dest_port, output seq_number, output ack_number,
    output tcp_flag_bits, output payload_offset, output payload_length, input ready
  );
  modport sink (
    input valid, input status, input is_tcp, input src_address, input dst_address,
    input source_port, input dest_port, input seq_number, input ack_number,
    input tcp_flag_bits, input payload_offset, input payload_length, output ready
  );
endinterface

@@ hdl/ehp_frame_track.sv @@
module ehp_frame_track #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic [7:0]                            byte_value,
  input  logic                                  last_byte,
  output ehp_pkg::hdr_state_t                   snap_hdr,
  output logic [$clog2(MAX_FRAME_BYTES+2)-1:0]  snap_count
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  ehp_pkg::hdr_state_t hdr;
  ehp_pkg::hdr_state_t hdr_next;
  logic [7:0]          l4_off;
  logic [CNT_W-1:0]    l4_pos;
  logic [CNT_W-1:0]    rel;

  always_comb begin
    hdr_next   = hdr;
    count_next = count;
    l4_off     = 8'(ehp_pkg::ETH_LEN) + {2'b00, hdr.header_len_words, 2'b00};
    l4_pos     = CNT_W'(l4_off);
    rel        = count - l4_pos;
    if (count <= MAX_CNT) begin
      count_next = count + 1'b1;
      if (count == CNT_W'(ehp_pkg::POS_VER_IHL)) begin
        hdr_next.header_len_words = byte_value[3:0];
        hdr_next.error_code = ((byte_value[7:4] != ehp_pkg::IP_VERSION) ||
                               (byte_value[3:0] < ehp_pkg::IHL_MIN)) ?
                              ehp_pkg::ERR_BAD_HDR : ehp_pkg::ERR_NONE;
      end else if (count == CNT_W'(ehp_pkg::POS_PROTO)) begin
        hdr_next.proto_number = byte_value;
      end else if (count >= CNT_W'(ehp_pkg::POS_SRC_ADDR) &&
                   count <  CNT_W'(ehp_pkg::POS_DST_ADDR)) begin
        hdr_next.source_addr_reg = {hdr.source_addr_reg[23:0], byte_value};
      end else if (count >= CNT_W'(ehp_pkg::POS_DST_ADDR) &&
                   count <  CNT_W'(ehp_pkg::MIN_L4_OFFSET)) begin
        hdr_next.dest_addr_reg = {hdr.dest_addr_reg[23:0], byte_value};
      end else if (count >= CNT_W'(ehp_pkg::MIN_L4_OFFSET) &&
                   hdr.header_len_words >= ehp_pkg::IHL_MIN &&
                   count >= l4_pos) begin
        if (rel < CNT_W'(4)) begin
          hdr_next.port_pair_reg = {hdr.port_pair_reg[23:0], byte_value};
        end else if (rel < CNT_W'(8)) begin
          hdr_next.seq_reg = {hdr.seq_reg[23:0], byte_value};
        end else if (rel < CNT_W'(12)) begin
          hdr_next.ack_reg = {hdr.ack_reg[23:0], byte_value};
        end else if (rel == CNT_W'(12)) begin
          hdr_next.data_offset_words = byte_value[7:4];
        end else if (rel == CNT_W'(13)) begin
          hdr_next.flag_reg = byte_value;
        end
      end
    end
  end

  // State clears after the last byte so the next frame starts fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      hdr   <= '0;
    end else if (take) begin
      if (last_byte) begin
        count <= '0;
        hdr   <= '0;
      end else begin
        count <= count_next;
        hdr   <= hdr_next;
      end
    end
  end

  assign snap_hdr   = hdr_next;
  assign snap_count = count_next;

endmodule

@@ hdl/eth_ipv4_l4_header_parser_core.sv @@
// Channel | Dir | Payload                                        | Transaction
// --------+-----+------------------------------------------------+----------------------------
// frame   | in  | byte_value, last_byte                          | one frame byte, wire order
// result  | out | status, is_tcp, addresses, ports, seq, ack,    | one summary per frame,
//         |     | tcp_flag_bits, payload_offset, payload_length  | after the last byte
//
// Cycles: one byte per cycle while frame.ready is high; once the last byte is taken, a summary
// moves from the header state through the frame summary register into the result register.
// Reset: synchronous rst clears the byte counter, header state and both valid flags.
// Stalls: frame.ready drops only while a summary is held and the result register
// cannot drain; non-last bytes and last bytes are then both held off.
`include "assert_macros.svh"

module eth_ipv4_l4_header_parser_core #(
  parameter int MAX_FRAME_BYTES = 16384
) (
  input logic       clk,
  input logic       rst,
  ehp_in_if.sink    frame,
  ehp_out_if.source result
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam int CMP_W = (CNT_W > 15) ? CNT_W : 15;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

  // Handshake / pipeline control
  logic take;
  logic res_load;
  logic sum_adv;

  // Header state snapshot from the byte tracker
  ehp_pkg::hdr_state_t snap_hdr;
  logic [CNT_W-1:0]    snap_count;

  // Frame summary stage
  logic                sum_valid;
  ehp_pkg::hdr_state_t sum_hdr;
  logic [CNT_W-1:0]    sum_count;

  // Result computation
  ehp_pkg::status_t status_next;
  logic             tcp_next;
  logic [CMP_W-1:0] len;
  logic [7:0]       l4_off;
  logic [7:0]       poff_tcp;
  logic [7:0]       poff;
  logic [CMP_W-1:0] plen;
  logic             ok;

  assign res_load    = !result.valid || result.ready;
  assign sum_adv     = sum_valid && res_load;
  assign frame.ready = !sum_valid || res_load;
  assign take        = frame.valid && frame.ready;

  ehp_frame_track #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .byte_value (frame.byte_value),
    .last_byte  (frame.last_byte),
    .snap_hdr   (snap_hdr),
    .snap_count (snap_count)
  );

  // Frame summary register: holds the finished header while the next frame runs
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (take && frame.last_byte) begin
      sum_valid <= 1'b1;
    end else if (sum_adv) begin
      sum_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame.last_byte) begin
      sum_hdr   <= snap_hdr;
      sum_count <= snap_count;
    end
  end

  // Status priority: oversize, short IP header, bad header, protocol checks
  always_comb begin
    len         = CMP_W'(sum_count);
    l4_off      = 8'(ehp_pkg::ETH_LEN) + {2'b00, sum_hdr.header_len_words, 2'b00};
    poff_tcp    = l4_off + {2'b00, sum_hdr.data_offset_words, 2'b00};
    status_next = ehp_pkg::STATUS_OK;
    tcp_next    = 1'b0;
    poff        = 8'd0;
    if (sum_count > MAX_CNT) begin
      status_next = ehp_pkg::STATUS_OVERSIZE;
    end else if (len < CMP_W'(ehp_pkg::MIN_L4_OFFSET)) begin
      status_next = ehp_pkg::STATUS_TRUNCATED;
    end else if (sum_hdr.error_code != ehp_pkg::ERR_NONE) begin
      status_next = ehp_pkg::STATUS_BAD_HDR;
    end else if (sum_hdr.proto_number == ehp_pkg::TCP_PROTO_NUM) begin
      tcp_next = 1'b1;
      if (len < CMP_W'(l4_off) + CMP_W'(ehp_pkg::TCP_MIN_LEN)) begin
        status_next = ehp_pkg::STATUS_TRUNCATED;
      end else begin
        poff = poff_tcp;
      end
    end else if (sum_hdr.proto_number == ehp_pkg::UDP_PROTO_NUM) begin
      if (len < CMP_W'(l4_off) + CMP_W'(ehp_pkg::UDP_LEN)) begin
        status_next = ehp_pkg::STATUS_TRUNCATED;
      end else begin
        poff = l4_off + 8'(ehp_pkg::UDP_LEN);
      end
    end else begin
      status_next = ehp_pkg::STATUS_BAD_PROTO;
    end
    ok   = (status_next == ehp_pkg::STATUS_OK);
    plen = (CMP_W'(poff) < len) ? (len - CMP_W'(poff)) : '0;
  end

  // Result register; all fields but status read zero on a failed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_adv) begin
      result.status         <= status_next;
      result.is_tcp         <= ok && tcp_next;
      result.src_address    <= ok ? sum_hdr.source_addr_reg : 32'd0;
      result.dst_address    <= ok ? sum_hdr.dest_addr_reg : 32'd0;
      result.source_port    <= ok ? sum_hdr.port_pair_reg[31:16] : 16'd0;
      result.dest_port      <= ok ? sum_hdr.port_pair_reg[15:0] : 16'd0;
      result.seq_number     <= (ok && tcp_next) ? sum_hdr.seq_reg : 32'd0;
      result.ack_number     <= (ok && tcp_next) ? sum_hdr.ack_reg : 32'd0;
      result.tcp_flag_bits  <= (ok && tcp_next) ? sum_hdr.flag_reg : 8'd0;
      result.payload_offset <= ok ? poff : 8'd0;
      result.payload_length <= ok ? plen[14:0] : 15'd0;
    end
  end

  // Checks
  `EHP_ASSERT_NEXT(a_last_fills_summary, clk, rst, take && frame.last_byte, sum_valid,
                   "last byte did not produce a frame summary")
  `EHP_ASSERT_IMP(a_fail_fields_zero, clk, rst,
                  result.valid && (result.status != ehp_pkg::STATUS_OK),
                  (result.is_tcp == 1'b0) && (result.src_address == 32'd0) &&
                  (result.payload_offset == 8'd0) && (result.payload_length == 15'd0),
                  "failed frame carries nonzero fields")
  `EHP_ASSERT_IMP(a_udp_no_tcp_fields, clk, rst,
                  result.valid && (result.status == ehp_pkg::STATUS_OK) && !result.is_tcp,
                  (result.seq_number == 32'd0) && (result.ack_number == 32'd0) &&
                  (result.tcp_flag_bits == 8'd0),
                  "UDP result carries TCP fields")
  `EHP_ASSERT_IMP(a_ok_offset_min, clk, rst,
                  result.valid && (result.status == ehp_pkg::STATUS_OK),
                  result.payload_offset >= 8'(ehp_pkg::MIN_L4_OFFSET),
                  "payload offset inside IP header")

endmodule
